>>> design/bitmap_first_bit_search_assert.svh
// assertion macros used by the bitmap search scan rtl
`ifndef BITMAP_FIRST_BIT_SEARCH_ASSERT_SVH
`define BITMAP_FIRST_BIT_SEARCH_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BFBS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define BFBS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/bfbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfbs_pkg;

	// largest bitmap length the block handles, in bytes
	localparam int unsigned MAX_BYTES = 1048576;

	// field and state widths
	localparam int LEN_W  = 21;
	localparam int POS_W  = 24;
	localparam int RES_W  = 25;
	localparam int BND_W  = 34;
	localparam int CFG_W  = 32;
	localparam int IDX_W  = 2;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BYTES);
	localparam logic [LEN_W-1:0] CNT_MAX = {LEN_W{1'b1}};
	localparam logic signed [RES_W-1:0] NO_HIT = -RES_W'(1);

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_BITMAP_BYTES = 2'd0;
	localparam logic [IDX_W-1:0] REG_RANGE_START  = 2'd1;
	localparam logic [IDX_W-1:0] REG_RANGE_STOP   = 2'd2;
	localparam logic [IDX_W-1:0] REG_WANTED_BIT   = 2'd3;

	// adjusted search window
	typedef struct packed {
		logic                    ok;
		logic [LEN_W-1:0]        len;
		logic signed [BND_W-1:0] lo;
		logic signed [BND_W-1:0] hi;
	} range_t;

	// index of the lowest set bit of a byte, 3 bits
	function automatic logic [2:0] lowest_set(input logic [7:0] v);
		logic [2:0] k;
		k = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) k = 3'(i);
		end
		return k;
	endfunction

endpackage

`default_nettype wire

>>> design/bfbs_range.sv
`timescale 1ns / 1ps
`default_nettype none

module bfbs_range (
	input  wire logic [bfbs_pkg::LEN_W-1:0] bitmap_bytes,
	input  wire logic [bfbs_pkg::CFG_W-1:0] range_start,
	input  wire logic [bfbs_pkg::CFG_W-1:0] range_stop,
	output bfbs_pkg::range_t                rng
);
	import bfbs_pkg::*;

	logic [LEN_W-1:0]        len;
	logic signed [BND_W-1:0] s_raw;
	logic signed [BND_W-1:0] e_raw;
	logic signed [BND_W-1:0] len_p1;
	logic signed [BND_W-1:0] s_adj;
	logic signed [BND_W-1:0] e_adj;

	// length saturates at the supported maximum
	assign len = (bitmap_bytes > MAX_LEN) ? MAX_LEN : bitmap_bytes;

	// negative bounds count back from the end
	assign s_raw  = BND_W'($signed(range_start));
	assign e_raw  = BND_W'($signed(range_stop));
	assign len_p1 = $signed({{(BND_W-LEN_W){1'b0}}, len}) + BND_W'(1);
	assign s_adj  = s_raw[BND_W-1] ? s_raw + len_p1 : s_raw;
	assign e_adj  = e_raw[BND_W-1] ? e_raw + len_p1 : e_raw;

	// window is bad if a bound stays negative or it is reversed
	always_comb begin
		rng.len = len;
		rng.lo  = s_adj;
		rng.hi  = e_adj;
		rng.ok  = !s_adj[BND_W-1] && !e_adj[BND_W-1] && (s_adj <= e_adj);
	end

endmodule

`default_nettype wire

>>> design/bfbs_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module bfbs_scan (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        go,
	input  wire logic [7:0]                  data,
	input  wire logic                        last,
	input  wire bfbs_pkg::range_t            rng,
	input  wire logic                        wanted,
	input  wire logic                        out_stall,
	output logic                             out_free,
	output logic                             out_valid,
	output logic [bfbs_pkg::RES_W-1:0]       bit_position
);
	import bfbs_pkg::*;

	`include "bitmap_first_bit_search_assert.svh"

	logic [LEN_W-1:0]        byte_counter_q;
	logic                    match_seen_q;
	logic [POS_W-1:0]        match_position_q;
	logic                    out_valid_q;
	logic [RES_W-1:0]        bit_position_q;

	logic signed [BND_W-1:0] idx;
	logic                    in_window;
	logic [7:0]              probe;
	logic                    hit;
	logic [POS_W-1:0]        hit_pos;
	logic                    seen_nxt;
	logic [POS_W-1:0]        pos_nxt;
	logic [RES_W-1:0]        result;

	// judge the byte at the current index
	assign idx       = $signed({{(BND_W-LEN_W){1'b0}}, byte_counter_q});
	assign in_window = rng.ok && (idx >= rng.lo) && (idx <= rng.hi)
		&& (byte_counter_q < rng.len);
	assign probe     = wanted ? data : ~data;
	assign hit       = in_window && !match_seen_q && (probe != 8'd0);
	assign hit_pos   = {byte_counter_q, lowest_set(probe)};
	assign seen_nxt  = match_seen_q || hit;
	assign pos_nxt   = hit ? hit_pos : match_position_q;

	// final answer for the word that closes the bitmap
	always_comb begin
		if (!rng.ok) begin
			result = NO_HIT;
		end else if (seen_nxt) begin
			result = {1'b0, pos_nxt};
		end else if (wanted) begin
			result = NO_HIT;
		end else begin
			result = {1'b0, rng.len, 3'd0};
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_counter_q   <= '0;
			match_seen_q     <= 1'b0;
			match_position_q <= '0;
		end else if (go) begin
			if (last) begin
				byte_counter_q   <= '0;
				match_seen_q     <= 1'b0;
				match_position_q <= '0;
			end else begin
				if (byte_counter_q != CNT_MAX) byte_counter_q <= byte_counter_q + LEN_W'(1);
				match_seen_q     <= seen_nxt;
				match_position_q <= pos_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= go && last;
		end
	end

	always_ff @(posedge clk) begin
		if (go && last) bit_position_q <= result;
	end

	assign out_valid    = out_valid_q;
	assign bit_position = bit_position_q;

	// checks
	`BFBS_ASSERT_NXT(a_clear_after_last, go && last, (byte_counter_q == '0) && !match_seen_q, "scan state not cleared after last word")
	`BFBS_ASSERT_IMP(a_match_behind_counter, match_seen_q, match_position_q[POS_W-1:3] < byte_counter_q, "stored match lies ahead of the byte counter")
	`BFBS_ASSERT_NXT(a_hit_recorded, go && !last && hit, match_seen_q, "first hit not recorded")
	`BFBS_ASSERT_NXT(a_result_held, out_valid_q && out_stall, out_valid_q, "stalled result dropped")

endmodule

`default_nettype wire

>>> design/bitmap_first_bit_search.sv
`timescale 1ns / 1ps
`default_nettype none

// First-bit search over a bitmap streamed one byte per word.
// Input channel: in_valid / in_stall with data_byte and last_byte; the bytes
// of one bitmap arrive in index order and last_byte marks the final one.
// Output channel: out_valid / out_stall with bit_position, one word for each
// bitmap, issued for its last byte: the first bit equal to wanted_bit within
// the byte window range_start..range_stop, or -1 / length*8 when none.
// Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
// Throughput: one byte per cycle unless a final byte waits on a stalled
// result register; the window compare and eight-bit priority encode are
// combinational and sit between the input and result registers. The last
// byte passes the input register, then the result register, to the output.
// Reset: configuration returns to length 1, window 0..-1, searching for ones;
// the byte counter and match state clear; no result is pending.
// Receiver stall: the result register holds its word; non-final bytes keep
// flowing, and a final byte waits in the input register, which then stalls
// the input channel until the result register frees.

module bitmap_first_bit_search (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [7:0]                    data_byte,
	input  wire logic                          last_byte,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic signed [bfbs_pkg::RES_W-1:0]  bit_position,
	input  wire logic                          cfg_we,
	input  wire logic [bfbs_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [bfbs_pkg::CFG_W-1:0]    cfg_data
);
	import bfbs_pkg::*;

	logic [LEN_W-1:0] bitmap_bytes_q;
	logic [CFG_W-1:0] range_start_q;
	logic [CFG_W-1:0] range_stop_q;
	logic             wanted_bit_q;

	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             last_s1;

	range_t           rng;
	logic             out_free;
	logic             go;
	logic [RES_W-1:0] position;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitmap_bytes_q <= LEN_W'(1);
			range_start_q  <= '0;
			range_stop_q   <= '1;
			wanted_bit_q   <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BITMAP_BYTES: bitmap_bytes_q <= cfg_data[LEN_W-1:0];
				REG_RANGE_START:  range_start_q  <= cfg_data;
				REG_RANGE_STOP:   range_stop_q   <= cfg_data;
				REG_WANTED_BIT:   wanted_bit_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// input register; a final byte waits here for the result register
	assign go       = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	bfbs_range u_range (
		.bitmap_bytes (bitmap_bytes_q),
		.range_start  (range_start_q),
		.range_stop   (range_stop_q),
		.rng          (rng)
	);

	bfbs_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (go),
		.data         (data_s1),
		.last         (last_s1),
		.rng          (rng),
		.wanted       (wanted_bit_q),
		.out_stall    (out_stall),
		.out_free     (out_free),
		.out_valid    (out_valid),
		.bit_position (position)
	);

	assign bit_position = $signed(position);

endmodule

`default_nettype wire
